// File: rtl/itds_pkg.sv
`timescale 1ns / 1ps

package itds_pkg;

  localparam int unsigned MAX_DIGITS = 64;
  localparam int unsigned MAX_RADIX  = 16;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned DIG_AW     = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

  // The divider retires DIV_BITS dividend bits per cycle.
  localparam int unsigned DIV_BITS   = 8;
  localparam int unsigned DIV_STEPS  = VALUE_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(MAX_RADIX);

  typedef enum logic {
    OP_DEC   = 1'b0,
    OP_RADIX = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_LOW  = 3'd0,
    CFG_A_HIGH = 3'd1,
    CFG_B_LOW  = 3'd2,
    CFG_B_HIGH = 3'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_READ,
    ST_SHOW
  } state_e;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] radix;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] tab_char(input logic [63:0] lo,
                                                  input logic [63:0] hi,
                                                  input logic [DIGIT_W-1:0] d);
    logic [63:0] w;
    w = d[3] ? hi : lo;
    return w[d[2:0]*CHAR_W +: CHAR_W];
  endfunction

endpackage

// File: rtl/itds_ram.sv
`timescale 1ns / 1ps

module itds_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/itds_div.sv
`timescale 1ns / 1ps

module itds_div
  import itds_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itds_pkg::div_req_t  req_i,
  output itds_pkg::div_rsp_t  rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [VALUE_W-1:0]   shift_q, shift_d;
  logic [DIGIT_W-1:0]   rem_q, rem_d;
  logic [DIGIT_W-1:0]   rem_step;
  logic [DIV_BITS-1:0]  qbits;
  logic [DIV_BITS-1:0]  top_bits;
  logic [RADIX_W-1:0]   trial;

  // Long division by a radix of at most 16: the partial remainder stays
  // below the radix, so each bit is a 5-bit compare and subtract.
  always_comb begin
    top_bits = shift_q[VALUE_W-1 -: DIV_BITS];
    rem_step = rem_q;
    qbits    = '0;
    trial    = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      trial = {rem_step, top_bits[i]};
      if (trial >= req_i.radix) begin
        trial    = trial - req_i.radix;
        qbits[i] = 1'b1;
      end
      rem_step = trial[DIGIT_W-1:0];
    end
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    if (busy_q) begin
      shift_d = {shift_q[VALUE_W-DIV_BITS-1:0], qbits};
      rem_d   = rem_step;
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      shift_d = req_i.dividend;
      rem_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = shift_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: rtl/integer_to_digit_string_unit.sv
`timescale 1ns / 1ps

// Integer to text converter. One request on the input channel (opcode, value,
// radix, table_select) yields a run of characters on the output channel, most
// significant digit first, with last_o high on the final one. Opcode 0 prints
// the low 32 bits as signed decimal with a leading minus for negatives;
// opcode 1 prints all 64 bits unsigned in radix 2..16 (clamped) using digit
// table A or B from the configuration registers.
// Digits are produced by one shared divider that retires 8 dividend bits per
// cycle; each digit passes through a start state, the divider steps and a
// store of the digit, and the digits are kept in a small RAM. Each character
// then passes through a RAM read and a show state. An item holds at most 64
// digits, plus a minus sign for a negative decimal. Input ready is high
// only while the block is idle. A stalled receiver simply holds the current
// character on the output until it is taken. Reset returns the block to idle
// and clears the digit tables to zero. Configuration must be written by the
// user only while the block is idle; the block itself does not enforce this.
module integer_to_digit_string_unit
  import itds_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           opcode_i,
  input  logic [itds_pkg::VALUE_W-1:0]   value_i,
  input  logic [itds_pkg::RADIX_W-1:0]   radix_i,
  input  logic                           table_select_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [itds_pkg::CHAR_W-1:0]    character_o,
  output logic                           last_o,
  input  logic                           cfg_we_i,
  input  logic [itds_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                    cfg_data_i
);

  state_e             state_q, state_d;
  logic               op_q, op_d;
  logic               tsel_q, tsel_d;
  logic               neg_q, neg_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DIG_AW-1:0]  idx_q, idx_d;

  logic [63:0] a_lo_q, a_hi_q, b_lo_q, b_hi_q;

  logic [RADIX_W-1:0] radix_in;
  logic [31:0]        mag32;
  logic               neg_in;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               ram_we;
  logic               ram_re;
  logic [DIGIT_W-1:0] ram_rdata;
  logic [CHAR_W-1:0]  digit_char;

  itds_div u_div (
    .clk_i,
    .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  itds_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (cnt_q[DIG_AW-1:0]),
    .wdata_i (div_rsp.remainder),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_lo_q <= '0;
      a_hi_q <= '0;
      b_lo_q <= '0;
      b_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_A_LOW:  a_lo_q <= cfg_data_i;
        CFG_A_HIGH: a_hi_q <= cfg_data_i;
        CFG_B_LOW:  b_lo_q <= cfg_data_i;
        CFG_B_HIGH: b_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (radix_i < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end else begin
      radix_in = radix_i;
    end
    neg_in = value_i[31];
    // The most negative value negates to itself, which reads correctly unsigned.
    mag32  = neg_in ? (~value_i[31:0] + 32'd1) : value_i[31:0];
  end

  always_comb begin
    if (op_q == OP_DEC) begin
      digit_char = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, ram_rdata};
    end else if (tsel_q) begin
      digit_char = tab_char(b_lo_q, b_hi_q, ram_rdata);
    end else begin
      digit_char = tab_char(a_lo_q, a_hi_q, ram_rdata);
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    tsel_d  = tsel_q;
    neg_d   = neg_q;
    radix_d = radix_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;

    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    character_o = digit_char;
    last_o      = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    div_req.start    = 1'b0;
    div_req.dividend = val_q;
    div_req.radix    = radix_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d   = opcode_i;
          tsel_d = table_select_i;
          cnt_d  = '0;
          if (opcode_i == OP_DEC) begin
            neg_d   = neg_in;
            radix_d = RADIX_DEC;
            val_d   = {32'd0, mag32};
          end else begin
            neg_d   = 1'b0;
            radix_d = radix_in;
            val_d   = value_i;
          end
          state_d = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          ram_we = 1'b1;
          val_d  = div_rsp.quotient;
          cnt_d  = cnt_q + 1'b1;
          if ((div_rsp.quotient == '0) || (cnt_q == CNT_W'(MAX_DIGITS - 1))) begin
            idx_d   = cnt_q[DIG_AW-1:0];
            state_d = neg_q ? ST_SIGN : ST_READ;
          end else begin
            state_d = ST_DIV_START;
          end
        end
      end
      ST_SIGN: begin
        out_valid_o = 1'b1;
        character_o = CHAR_MINUS;
        if (out_ready_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid_o = 1'b1;
        last_o      = (idx_q == '0);
        if (out_ready_i) begin
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      neg_q   <= 1'b0;
      val_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      neg_q   <= neg_d;
      val_q   <= val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    tsel_q  <= tsel_d;
    radix_q <= radix_d;
  end

endmodule

// File: tb/integer_to_digit_string_unit_tb.sv
`timescale 1ns / 1ps

module integer_to_digit_string_unit_tb;
  import itds_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 47;

  typedef struct packed {
    opcode_e              op;
    logic [VALUE_W-1:0]   value;
    logic [RADIX_W-1:0]   radix;
    logic                 tsel;
  } conv_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // Predicts the text of every accepted conversion request and checks the
  // characters that come out against it, oldest first.
  class digit_string_checker;
    logic [127:0]     table_a;
    logic [127:0]     table_b;
    logic [CNT_W-1:0] digit_count;
    logic             negative;
    text_char_t       pending_chars[$];
    int unsigned      requests;
    int unsigned      chars_checked;
    int unsigned      mismatches;

    function new();
      table_a       = '0;
      table_b       = '0;
      digit_count   = '0;
      negative      = 1'b0;
      requests      = 0;
      chars_checked = 0;
      mismatches    = 0;
    endfunction

    function void set_table(cfg_idx_e idx, logic [63:0] data);
      case (idx)
        CFG_A_LOW:  table_a[63:0]   = data;
        CFG_A_HIGH: table_a[127:64] = data;
        CFG_B_LOW:  table_b[63:0]   = data;
        CFG_B_HIGH: table_b[127:64] = data;
        default: ;
      endcase
    endfunction

    function void note_request(conv_req_t r);
      logic [VALUE_W-1:0] rest;
      logic [VALUE_W-1:0] base;
      logic [31:0]        low;
      logic [DIGIT_W-1:0] digs[MAX_DIGITS];
      logic [127:0]       tab;
      logic [CHAR_W-1:0]  ch;
      int                 n;
      requests++;
      n = 0;
      if (r.op == OP_DEC) begin
        low      = r.value[31:0];
        negative = low[31];
        // The magnitude of the most negative value still fits in 32 bits.
        if (negative) low = -low;
        rest = {32'd0, low};
        base = VALUE_W'(RADIX_DEC);
      end else begin
        negative = 1'b0;
        rest     = r.value;
        if (r.radix < RADIX_MIN) base = VALUE_W'(RADIX_MIN);
        else if (r.radix > RADIX_MAX) base = VALUE_W'(RADIX_MAX);
        else base = VALUE_W'(r.radix);
      end
      do begin
        digs[n] = DIGIT_W'(rest % base);
        rest    = rest / base;
        n++;
      end while (rest != 0 && n < int'(MAX_DIGITS));
      digit_count = CNT_W'(n);
      tab = r.tsel ? table_b : table_a;
      if (negative) pending_chars.push_back('{CHAR_MINUS, 1'b0});
      for (int k = n - 1; k >= 0; k--) begin
        if (r.op == OP_DEC) ch = CHAR_ZERO + CHAR_W'(digs[k]);
        else ch = tab[digs[k]*CHAR_W +: CHAR_W];
        pending_chars.push_back('{ch, k == 0});
      end
    endfunction

    task report(string what, logic [CHAR_W-1:0] got, logic [CHAR_W-1:0] want);
      mismatches++;
      $display("%0t: mismatch in %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
    endtask

    task check_char(logic [CHAR_W-1:0] ch, logic last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        report("character with nothing pending", ch, '0);
        return;
      end
      chars_checked++;
      want = pending_chars.pop_front();
      if (ch !== want.ch) report("character", ch, want.ch);
      if (last !== want.last) report("last flag", CHAR_W'(last), CHAR_W'(want.last));
    endtask

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 opcode = 1'b0;
  logic [VALUE_W-1:0]   value = '0;
  logic [RADIX_W-1:0]   radix = '0;
  logic                 table_select = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [CHAR_W-1:0]    character;
  logic                 last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  logic                 idling = 1'b0;
  int unsigned          stall_left = 0;
  int unsigned          quiet_cycles = 0;
  int unsigned          settings = 0;
  digit_string_checker  sb;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  integer_to_digit_string_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .value_i        (value),
    .radix_i        (radix),
    .table_select_i (table_select),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .character_o    (character),
    .last_o         (last),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // Output side: check every character transaction and stall in bursts.
  always @(posedge clk_i) begin
    if (out_valid && out_ready) sb.check_char(character, last);
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_ready <= 1'b1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(1, 13);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles.", QUIET_LIMIT);
      $display("integer_to_digit_string_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic send_request(opcode_e op, logic [VALUE_W-1:0] v, logic [RADIX_W-1:0] rad,
                              logic tsel);
    conv_req_t r;
    r = '{op, v, rad, tsel};
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    value        <= v;
    radix        <= rad;
    table_select <= tsel;
    do @(posedge clk_i); while (!in_ready);
    sb.note_request(r);
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    sb.set_table(idx, data);
  endtask

  task automatic write_tables(logic [63:0] a_lo, logic [63:0] a_hi, logic [63:0] b_lo,
                              logic [63:0] b_hi);
    write_reg(CFG_A_LOW, a_lo);
    write_reg(CFG_A_HIGH, a_hi);
    write_reg(CFG_B_LOW, b_lo);
    write_reg(CFG_B_HIGH, b_hi);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    opcode_e             op;
    logic [VALUE_W-1:0]  v;
    logic [31:0]         low;
    logic [RADIX_W-1:0]  rad;
    logic [63:0]         tabs[4];
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Tables are still all zero from reset.
    send_request(OP_RADIX, 64'hFF, 5'd16, 1'b0);
    send_request(OP_RADIX, 64'h5, 5'd2, 1'b1);

    for (int p = 0; p < 5; p++) begin
      in_valid <= 1'b0;
      wait_idle();
      case (p)
        0: begin
          tabs = '{64'h3736353433323130, 64'h6665646362613938,
                   64'h3736353433323130, 64'h4645444342413938};
        end
        1: tabs = '{'1, '1, '0, '0};
        2: tabs = '{'0, '0, '1, '1};
        default: begin
          foreach (tabs[i]) tabs[i] = {$urandom(), $urandom()};
        end
      endcase
      write_tables(tabs[0], tabs[1], tabs[2], tabs[3]);
      idling <= (p != 2 && p != 4);

      if (p == 0) begin
        send_request(OP_DEC, 64'd0, 5'd10, 1'b0);
        send_request(OP_DEC, 64'd1, 5'd10, 1'b0);
        send_request(OP_DEC, 64'hFFFF_FFFF, 5'd10, 1'b0);
        send_request(OP_DEC, 64'h7FFF_FFFF, 5'd10, 1'b0);
        send_request(OP_DEC, 64'h8000_0000, 5'd16, 1'b1);
        // Upper bits, radix and table select must all be ignored for decimal.
        send_request(OP_DEC, 64'hDEAD_BEEF_0000_007B, 5'd0, 1'b1);
        send_request(OP_DEC, 64'hFFFF_FFFF_FFFF_FFFE, 5'd31, 1'b0);
        send_request(OP_DEC, 64'h0000_0001_8000_0000, 5'd2, 1'b1);
        send_request(OP_DEC, 64'd1000000000, 5'd10, 1'b0);
        send_request(OP_RADIX, 64'd0, 5'd16, 1'b0);
        send_request(OP_RADIX, 64'd0, 5'd2, 1'b1);
        send_request(OP_RADIX, 64'd1, 5'd2, 1'b0);
        send_request(OP_RADIX, '1, 5'd2, 1'b0);
        send_request(OP_RADIX, '1, 5'd16, 1'b1);
        send_request(OP_RADIX, 64'h8000_0000_0000_0000, 5'd2, 1'b1);
        // Radix values outside 2..16 are clamped.
        send_request(OP_RADIX, '1, 5'd0, 1'b0);
        send_request(OP_RADIX, 64'h1234, 5'd1, 1'b1);
        send_request(OP_RADIX, 64'hFEDC_BA98_7654_3210, 5'd31, 1'b0);
        send_request(OP_RADIX, 64'hFEDC_BA98_7654_3210, 5'd17, 1'b1);
        send_request(OP_RADIX, 64'd12345678901234567890, 5'd10, 1'b0);
        send_request(OP_RADIX, 64'h0123_4567_89AB_CDEF, 5'd3, 1'b1);
        send_request(OP_RADIX, 64'h0123_4567_89AB_CDEF, 5'd7, 1'b0);
        send_request(OP_RADIX, '1, 5'd15, 1'b1);
      end

      repeat (PHASE_ITEMS) begin
        op = opcode_e'($urandom_range(0, 1));
        v  = {$urandom(), $urandom()};
        if (op == OP_DEC) begin
          low = $urandom() >> $urandom_range(0, 31);
          if ($urandom_range(0, 1) == 1) low = -low;
          v[31:0] = low;
        end else begin
          v = v >> $urandom_range(0, 63);
        end
        if ($urandom_range(0, 7) == 0) rad = RADIX_W'($urandom_range(0, 31));
        else rad = RADIX_W'($urandom_range(2, 16));
        send_request(op, v, rad, 1'($urandom_range(0, 1)));
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Converted %0d requests into %0d checked characters over %0d table settings.",
             sb.requests, sb.chars_checked, settings);
    $display("Mismatches found: %0d.", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("integer_to_digit_string_unit_tb: PASS");
    end else begin
      $display("integer_to_digit_string_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: integer_to_digit_string_unit.f
rtl/itds_pkg.sv
rtl/itds_ram.sv
rtl/itds_div.sv
rtl/integer_to_digit_string_unit.sv
tb/integer_to_digit_string_unit_tb.sv
